// File: rtl/wfc_pkg.sv
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared types, register indexes and helpers of the 3x3 window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wfc_pkg;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 128;

  localparam int PIX_W  = 16;
  localparam int COEF_W = 16;
  localparam int KROW_W = 48;
  localparam int SUM_W  = 35;
  localparam int POS_W  = 7;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_FRAME_ROWS    = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_COLS    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KERNEL_MID    = 3'd3;
  localparam logic [IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  localparam logic [KROW_W-1:0] KERNEL_MID_RST = 48'h0000_0001_0000;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic [2:0][KROW_W-1:0] kern_t;

  // one window column, rows from top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             done;
  } meta_t;

  typedef struct packed {
    logic  rows_bot;
    logic  cols_end;
    meta_t meta;
  } job_t;

  // window index used by kernel index n; clamp replicates the far edge
  function automatic logic [1:0] map_idx(logic clamp, logic [1:0] n);
    logic [1:0] r;
    r = n;
    if (clamp) begin
      r = (n == 2'd0) ? 2'd1 : 2'd2;
    end
    return r;
  endfunction

  function automatic pix_t col_pick(col_t c, logic [1:0] r);
    pix_t p;
    case (r)
      2'd0:    p = c.top;
      2'd1:    p = c.mid;
      default: p = c.bot;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wfc_cell.sv
// ----------------------------------------------------------------------------
// wfc_cell
// One column of the 3x3 window; takes its neighbor's column on a shift, or
// the new column when a row starts.
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          load_all,
  input  wfc_pkg::col_t new_col,
  input  wfc_pkg::col_t prev_col,
  output wfc_pkg::col_t q
);
  import wfc_pkg::*;

  col_t q_r;
  col_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = load_all ? new_col : prev_col;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: rtl/wfc_mac.sv
// ----------------------------------------------------------------------------
// wfc_mac
// Three-stage multiply-accumulate: nine products, three row sums, total.
// ----------------------------------------------------------------------------
`default_nettype none

module wfc_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wfc_pkg::col_t [2:0]               win,
  input  wfc_pkg::job_t                     job,
  input  wfc_pkg::kern_t                    kernel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wfc_pkg::SUM_W-1:0]  filtered,
  output wfc_pkg::meta_t                    meta
);
  import wfc_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  logic signed [31:0] prod_r   [9];
  logic signed [31:0] prod_nxt [9];
  meta_t              s1_meta_r, s2_meta_r, s3_meta_r;

  logic signed [33:0] rsum_r   [3];
  logic signed [33:0] rsum_nxt [3];

  logic signed [SUM_W-1:0] total_r;
  logic signed [SUM_W-1:0] total_nxt;

  assign s3_rdy   = !s3_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_comb begin
    logic [1:0]         ri;
    logic [1:0]         ci;
    logic signed [31:0] px;
    logic signed [31:0] cf;
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        ri = map_idx(job.rows_bot, 2'(k));
        ci = map_idx(job.cols_end, 2'(l));
        px = 32'(col_pick(win[ci], ri));
        cf = 32'($signed(kernel[k][COEF_W*l +: COEF_W]));
        prod_nxt[k*3+l] = px * cf;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum_nxt[k] = 34'(prod_r[k*3]) + 34'(prod_r[k*3+1]) + 34'(prod_r[k*3+2]);
    end
    total_nxt = SUM_W'(rsum_r[0]) + SUM_W'(rsum_r[1]) + SUM_W'(rsum_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      prod_r    <= prod_nxt;
      s1_meta_r <= job.meta;
    end
    if (s2_rdy) begin
      rsum_r    <= rsum_nxt;
      s2_meta_r <= s1_meta_r;
    end
    if (s3_rdy) begin
      total_r   <= total_nxt;
      s3_meta_r <= s2_meta_r;
    end
  end

  assign out_valid = s3_v_r;
  assign filtered  = total_r;
  assign meta      = s3_meta_r;

endmodule

`default_nettype wire

// File: rtl/window_filter_3x3_clamped.sv
// ----------------------------------------------------------------------------
// window_filter_3x3_clamped
// Path: a pixel's results pass the input, window and MAC stages in turn.
// Throughput: one pixel per cycle while the output does not stall and a pixel
// releases at most one result; a pixel releasing n results holds the window
// stage while its n jobs issue singly to the MAC (two per pixel on the last
// row, up to four at a row end).
// Reset: synchronous; 128x128 frame, identity kernel; line store not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module window_filter_3x3_clamped #(
  parameter int MAX_COLS = wfc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = wfc_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // pixel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [55:0]                   out_tdata,  // filtered, out_row, out_col
  output logic                          out_tlast,  // run_last
  output logic [0:0]                    out_tuser,  // frame_done
  input  logic                          cfg_we,
  input  logic [wfc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [wfc_pkg::KROW_W-1:0]    cfg_wdata
);
  import wfc_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int AW = $clog2(MAX_COLS);

  localparam int JB_UP_MID  = 0;
  localparam int JB_UP_END  = 1;
  localparam int JB_BOT_MID = 2;
  localparam int JB_BOT_END = 3;

  // configuration
  logic [7:0] frame_rows_r, frame_rows_nxt;
  logic [7:0] frame_cols_r, frame_cols_nxt;
  kern_t      kernel_r, kernel_nxt;
  logic       restart;

  // position counters
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] nr, i_eff;
  logic [CW-1:0] nc, j_eff;
  logic [3:0]    mask_in;

  // input stage
  logic          accept;
  logic          a_valid_r;
  logic          a_move;
  pix_t          a_pix_r;
  logic [RW-1:0] a_row_r;
  logic [CW-1:0] a_col_r;
  logic [3:0]    a_mask_r;
  logic [31:0]   line_mem [MAX_COLS];
  logic [31:0]   mem_q_r;
  logic          byp_r;
  logic [31:0]   byp_q_r;
  logic [31:0]   rd_word;
  logic [31:0]   wr_word;

  // window and job stage
  col_t            new_col;
  col_t [2:0]      win;
  col_t [2:0]      chain_in;
  logic            load_all;
  logic [3:0]      b_mask_r;
  logic [POS_W-1:0] b_row_r;
  logic [POS_W-1:0] b_col_r;
  logic [3:0]      pick;
  logic [3:0]      mask_after;
  logic            b_free;
  logic            job_valid;
  logic            job_fire;
  logic            mac_ready;
  job_t            job;

  logic signed [SUM_W-1:0] filtered;
  meta_t                   o_meta;

  // ---------------- configuration ----------------
  always_comb begin
    frame_rows_nxt = frame_rows_r;
    frame_cols_nxt = frame_cols_r;
    kernel_nxt     = kernel_r;
    restart        = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ROWS: begin
          frame_rows_nxt = cfg_wdata[7:0];
          restart        = 1'b1;
        end
        REG_FRAME_COLS: begin
          frame_cols_nxt = cfg_wdata[7:0];
          restart        = 1'b1;
        end
        REG_KERNEL_TOP:    kernel_nxt[0] = cfg_wdata;
        REG_KERNEL_MID:    kernel_nxt[1] = cfg_wdata;
        REG_KERNEL_BOTTOM: kernel_nxt[2] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= 8'd128;
      frame_cols_r <= 8'd128;
      kernel_r     <= {KROW_W'(0), KERNEL_MID_RST, KROW_W'(0)};
    end else begin
      frame_rows_r <= frame_rows_nxt;
      frame_cols_r <= frame_cols_nxt;
      kernel_r     <= kernel_nxt;
    end
  end

  // ---------------- position ----------------
  always_comb begin
    if (frame_rows_r == 8'd0) begin
      nr = RW'(1);
    end else if (int'(frame_rows_r) > MAX_ROWS) begin
      nr = RW'(MAX_ROWS);
    end else begin
      nr = RW'(frame_rows_r);
    end
    if (frame_cols_r == 8'd0) begin
      nc = CW'(1);
    end else if (int'(frame_cols_r) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(frame_cols_r);
    end
  end

  always_comb begin
    i_eff = in_row_r;
    j_eff = in_col_r;
    if (in_row_r >= nr || in_col_r >= nc) begin
      i_eff = '0;
      j_eff = '0;
    end
    mask_in[JB_UP_MID]  = (i_eff != '0) && (j_eff != '0);
    mask_in[JB_UP_END]  = (i_eff != '0) && (j_eff == nc - CW'(1));
    mask_in[JB_BOT_MID] = (i_eff == nr - RW'(1)) && (j_eff != '0);
    mask_in[JB_BOT_END] = (i_eff == nr - RW'(1)) && (j_eff == nc - CW'(1));

    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (restart) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end else if (accept) begin
      if (j_eff + CW'(1) >= nc) begin
        in_col_nxt = '0;
        in_row_nxt = (i_eff + RW'(1) >= nr) ? '0 : i_eff + RW'(1);
      end else begin
        in_col_nxt = j_eff + CW'(1);
        in_row_nxt = i_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
    end
  end

  // ---------------- input stage and line store ----------------
  assign in_tready = !a_valid_r || a_move;
  assign accept    = in_tvalid && in_tready;
  assign a_move    = a_valid_r && b_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r  <= pix_t'(in_tdata);
      a_row_r  <= i_eff;
      a_col_r  <= j_eff;
      a_mask_r <= mask_in;
      byp_r    <= a_move && (j_eff[AW-1:0] == a_col_r[AW-1:0]);
      byp_q_r  <= wr_word;
    end
  end

  // word per column: older line in the upper half, previous line in the lower
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q_r <= line_mem[j_eff[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      line_mem[a_col_r[AW-1:0]] <= wr_word;
    end
  end

  assign rd_word = byp_r ? byp_q_r : mem_q_r;
  assign wr_word = {rd_word[15:0], a_pix_r};

  always_comb begin
    new_col.bot = a_pix_r;
    new_col.mid = (a_row_r != '0) ? pix_t'(rd_word[15:0]) : a_pix_r;
    new_col.top = (int'(a_row_r) >= 2) ? pix_t'(rd_word[31:16]) : new_col.mid;
  end

  // ---------------- window cells ----------------
  assign load_all    = (a_col_r == '0);
  assign chain_in[2] = new_col;
  assign chain_in[1] = win[2];
  assign chain_in[0] = win[1];

  for (genvar g = 0; g < 3; g++) begin : g_cell
    wfc_cell u_cell (
      .clk      (clk),
      .shift_en (a_move),
      .load_all (load_all),
      .new_col  (new_col),
      .prev_col (chain_in[g]),
      .q        (win[g])
    );
  end

  // ---------------- job issue ----------------
  always_comb begin
    pick = 4'b0000;
    if (b_mask_r[JB_UP_MID]) begin
      pick[JB_UP_MID] = 1'b1;
    end else if (b_mask_r[JB_UP_END]) begin
      pick[JB_UP_END] = 1'b1;
    end else if (b_mask_r[JB_BOT_MID]) begin
      pick[JB_BOT_MID] = 1'b1;
    end else if (b_mask_r[JB_BOT_END]) begin
      pick[JB_BOT_END] = 1'b1;
    end
    mask_after = b_mask_r & ~pick;
    job_valid  = (b_mask_r != 4'b0000);
    job_fire   = job_valid && mac_ready;
    b_free     = !job_valid || (job_fire && mask_after == 4'b0000);

    job.rows_bot  = pick[JB_BOT_MID] || pick[JB_BOT_END];
    job.cols_end  = pick[JB_UP_END] || pick[JB_BOT_END];
    job.meta.row  = job.rows_bot ? b_row_r : b_row_r - POS_W'(1);
    job.meta.col  = job.cols_end ? b_col_r : b_col_r - POS_W'(1);
    job.meta.last = (mask_after == 4'b0000);
    job.meta.done = pick[JB_BOT_END];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_mask_r <= 4'b0000;
    end else if (a_move) begin
      b_mask_r <= a_mask_r;
    end else if (job_fire) begin
      b_mask_r <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_row_r <= POS_W'(a_row_r);
      b_col_r <= POS_W'(a_col_r);
    end
  end

  // ---------------- multiply-accumulate ----------------
  wfc_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (job_valid),
    .in_ready  (mac_ready),
    .win       (win),
    .job       (job),
    .kernel    (kernel_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .filtered  (filtered),
    .meta      (o_meta)
  );

  assign out_tdata    = {7'd0, o_meta.col, o_meta.row, filtered};
  assign out_tlast    = o_meta.last;
  assign out_tuser[0] = o_meta.done;

`ifndef ASSERT_OFF
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end result not marked last");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !a_move |=> a_valid_r && $stable(a_pix_r))
    else $error("pending pixel lost");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> a_valid_r)
    else $error("accepted pixel not held");

  a_top_row_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && a_row_r == '0 |-> !a_mask_r[JB_UP_MID] && !a_mask_r[JB_UP_END])
    else $error("row above requested on first row");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for window_filter_3x3_clamped
// Streams signed pixels through the 3x3 clamped-border filter. A short table
// of directed transactions covers the reset kernel, the extreme sums, frame
// sizes of zero and a mid-frame restart. Random phases follow. They use small
// frames, one tall and one wide frame above the size limit, random kernels,
// bursty input and a stalling output. Every result is checked field by field
// against a behavioral model of the line stores and the window.
// ----------------------------------------------------------------------------
module testbench;
  import wfc_pkg::*;

  localparam int SETTLE_CYCLES = 12;    // pipeline latency plus margin
  localparam int IDLE_LIMIT    = 2000;  // quiet stretch that ends the run as a failure
  localparam int PIXEL_TARGET  = 430;
  localparam int LINE_MAX      = MAX_COLS_DEF;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
    logic                    done;
  } px_result_t;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t              kind;
    logic [IDX_W-1:0]        idx;
    logic [KROW_W-1:0]       value;
    logic                    chk;
    logic signed [SUM_W-1:0] want;
  } step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;     // pixel
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;         // filtered, out_row, out_col
  logic              out_tlast;         // run_last
  logic [0:0]        out_tuser;         // frame_done
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = REG_FRAME_ROWS;
  logic [KROW_W-1:0] cfg_wdata = '0;

  // model state
  pix_t              line_mem [0:1][0:LINE_MAX-1];
  pix_t              win [0:2][0:2];
  int unsigned       at_row;
  int unsigned       at_col;
  logic [7:0]        rows_reg;
  logic [7:0]        cols_reg;
  logic [KROW_W-1:0] krow [0:2];
  px_result_t        pending_filtered [$];
  step_t             steps [$];

  int pixels_sent;
  int results_seen;
  int frames_done;
  int phases_run;
  int mismatches;
  int quiet_cycles;
  int stall_mode;
  int stall_left;
  int stall_phase;

  window_filter_3x3_clamped dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void model_reset();
    for (int b = 0; b < 2; b++) begin
      for (int c = 0; c < LINE_MAX; c++) begin
        line_mem[b][c] = '0;
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win[r][c] = '0;
      end
    end
    at_row   = 0;
    at_col   = 0;
    rows_reg = 8'd128;
    cols_reg = 8'd128;
    krow[0]  = '0;
    krow[1]  = KERNEL_MID_RST;
    krow[2]  = '0;
  endfunction

  function automatic int unsigned clamp_dim(logic [7:0] v);
    if (v == 8'd0) begin
      return 1;
    end
    if (v > LINE_MAX) begin
      return LINE_MAX;
    end
    return v;
  endfunction

  function automatic void model_write(logic [IDX_W-1:0] idx, logic [KROW_W-1:0] v);
    case (idx)
      REG_FRAME_ROWS: begin
        rows_reg = v[7:0];
        at_row = 0;
        at_col = 0;
      end
      REG_FRAME_COLS: begin
        cols_reg = v[7:0];
        at_row = 0;
        at_col = 0;
      end
      REG_KERNEL_TOP:    krow[0] = v;
      REG_KERNEL_MID:    krow[1] = v;
      REG_KERNEL_BOTTOM: krow[2] = v;
      default: ;
    endcase
  endfunction

  // bottom rows / right column of the window replicate the edge when clamped
  function automatic px_result_t weigh(logic rows_bot, logic cols_end, int unsigned r,
                                       int unsigned c, logic done);
    px_result_t res;
    longint     acc;
    pix_t       coef;
    int         wr;
    int         wc;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        wr   = rows_bot ? ((k == 0) ? 1 : 2) : k;
        wc   = cols_end ? ((l == 0) ? 1 : 2) : l;
        coef = krow[k][16*l +: 16];
        acc += longint'(coef) * longint'(win[wr][wc]);
      end
    end
    res.sum  = acc[SUM_W-1:0];
    res.row  = POS_W'(r);
    res.col  = POS_W'(c);
    res.last = 1'b0;
    res.done = done;
    return res;
  endfunction

  function automatic void convolve_pixel(pix_t p);
    int unsigned nr;
    int unsigned nc;
    int unsigned i;
    int unsigned j;
    pix_t        older;
    pix_t        prev;
    pix_t        top;
    pix_t        mid;
    px_result_t  batch [$];
    nr = clamp_dim(rows_reg);
    nc = clamp_dim(cols_reg);
    if (at_row >= nr || at_col >= nc) begin
      at_row = 0;
      at_col = 0;
    end
    i = at_row;
    j = at_col;
    older = line_mem[1][j];
    prev  = line_mem[0][j];
    line_mem[1][j] = prev;
    line_mem[0][j] = p;
    mid = (i >= 1) ? prev : p;
    top = (i >= 2) ? older : mid;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = p;
    if (j == 0) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][2];
        win[r][1] = win[r][2];
      end
    end
    if (i >= 1) begin
      if (j >= 1) batch.push_back(weigh(1'b0, 1'b0, i - 1, j - 1, 1'b0));
      if (j == nc - 1) batch.push_back(weigh(1'b0, 1'b1, i - 1, nc - 1, 1'b0));
    end
    if (i == nr - 1) begin
      if (j >= 1) batch.push_back(weigh(1'b1, 1'b0, i, j - 1, 1'b0));
      if (j == nc - 1) batch.push_back(weigh(1'b1, 1'b1, i, nc - 1, 1'b1));
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[n]) pending_filtered.push_back(batch[n]);
    j++;
    if (j >= nc) begin
      j = 0;
      i++;
      if (i >= nr) i = 0;
    end
    at_row = i;
    at_col = j;
  endfunction

  function automatic void add_write(logic [IDX_W-1:0] idx, logic [KROW_W-1:0] v);
    step_t s;
    s.kind  = STEP_WRITE;
    s.idx   = idx;
    s.value = v;
    s.chk   = 1'b0;
    s.want  = '0;
    steps.push_back(s);
  endfunction

  function automatic void add_pixel(pix_t p, logic chk, logic signed [SUM_W-1:0] want);
    step_t s;
    s.kind  = STEP_PIXEL;
    s.idx   = REG_FRAME_ROWS;
    s.value = '0;
    s.value[PIX_W-1:0] = p;
    s.chk   = chk;
    s.want  = want;
    steps.push_back(s);
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return pix_t'(int'($urandom_range(0, 16)) - 8);
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] rand_krow();
    logic [KROW_W-1:0] v;
    v = '0;
    case ($urandom_range(0, 5))
      0: v = {3{16'h8000}};
      1: v = {3{16'h7fff}};
      2: v[16*$urandom_range(0, 2) +: 16] = 16'h0001;
      3: begin
        for (int l = 0; l < 3; l++) v[16*l +: 16] = 16'(int'($urandom_range(0, 8)) - 4);
      end
      default: v = {16'($urandom), $urandom};
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [KROW_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    model_write(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold input low until every pending result is out, then wait out the pipe
  task automatic settle(input int tail);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic send_pixel(input pix_t p);
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    convolve_pixel(p);
    pixels_sent++;
  endtask

  task automatic run_phase(input logic [7:0] rows_w, input logic [7:0] cols_w,
                           input bit set_dims, input int count, input bit bursty);
    int gap;
    int burst_left;
    int drain_at;
    settle(SETTLE_CYCLES);
    if (set_dims) begin
      write_reg(REG_FRAME_ROWS, {40'b0, rows_w});
      write_reg(REG_FRAME_COLS, {40'b0, cols_w});
    end
    if ($urandom_range(0, 3) != 0) write_reg(REG_KERNEL_TOP, rand_krow());
    if ($urandom_range(0, 3) != 0) write_reg(REG_KERNEL_MID, rand_krow());
    if ($urandom_range(0, 3) != 0) write_reg(REG_KERNEL_BOTTOM, rand_krow());
    drain_at   = $urandom_range(0, count - 1);
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (n == drain_at && n != 0) settle(0);
      if (bursty) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, 10);
          if (gap > 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
      end
      send_pixel(rand_pixel());
    end
    phases_run++;
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t  %s", $time, what);
  endtask

  // output stall pattern: stretches of always-ready, random and sparse ready
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 2) != 0);
      2:       out_tready <= (stall_phase % 5 == 0);
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    px_result_t got;
    px_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.sum  = out_tdata[SUM_W-1:0];
      got.row  = out_tdata[SUM_W +: POS_W];
      got.col  = out_tdata[SUM_W+POS_W +: POS_W];
      got.last = out_tlast;
      got.done = out_tuser[0];
      if (got.done) frames_done++;
      if (pending_filtered.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction: sum=%0d row=%0d col=%0d",
                                got.sum, got.row, got.col));
      end else begin
        exp_r = pending_filtered.pop_front();
        if (got.sum !== exp_r.sum || got.row !== exp_r.row || got.col !== exp_r.col ||
            got.last !== exp_r.last || got.done !== exp_r.done) begin
          note_mismatch($sformatf(
            "exp %0d (%0d,%0d) last=%b done=%b / got %0d (%0d,%0d) last=%b done=%b",
            exp_r.sum, exp_r.row, exp_r.col, exp_r.last, exp_r.done,
            got.sum, got.row, got.col, got.last, got.done));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL window_filter_3x3_clamped");
      $finish;
    end
  end

  initial begin
    logic [7:0] rows_w;
    logic [7:0] cols_w;
    bit         set_dims;
    int         area;
    int         count;
    stall_mode   = 0;
    stall_left   = 0;
    stall_phase  = 0;
    pixels_sent  = 0;
    results_seen = 0;
    frames_done  = 0;
    phases_run   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    model_reset();

    // 2x2 frame, identity kernel from reset
    add_write(REG_FRAME_ROWS, 48'd2);
    add_write(REG_FRAME_COLS, 48'd2);
    add_pixel(16'sh7fff, 1'b0, '0);
    add_pixel(16'sh8000, 1'b0, '0);
    add_pixel(16'sd1, 1'b0, '0);
    add_pixel(-16'sd1, 1'b1, -35'sd1);
    // zero sizes act as 1x1; every tap sees the same pixel
    add_write(REG_FRAME_ROWS, 48'd0);
    add_write(REG_FRAME_COLS, 48'd0);
    add_write(REG_KERNEL_TOP, {3{16'h8000}});
    add_write(REG_KERNEL_MID, {3{16'h8000}});
    add_write(REG_KERNEL_BOTTOM, {3{16'h8000}});
    add_pixel(16'sh7fff, 1'b1, -35'sd9663381504);
    add_pixel(16'sh8000, 1'b1, 35'sd9663676416);
    add_pixel(16'sd0, 1'b1, 35'sd0);
    add_write(REG_KERNEL_TOP, {3{16'h7fff}});
    add_write(REG_KERNEL_MID, {3{16'h7fff}});
    add_write(REG_KERNEL_BOTTOM, {3{16'h7fff}});
    add_pixel(16'sh7fff, 1'b1, 35'sd9663086601);
    add_pixel(16'sh8000, 1'b1, -35'sd9663381504);
    // 3x3 frame, asymmetric kernel, restarted partway through
    add_write(REG_FRAME_ROWS, 48'd3);
    add_write(REG_FRAME_COLS, 48'd3);
    add_write(REG_KERNEL_TOP, 48'h0003_0002_0001);
    add_write(REG_KERNEL_MID, 48'hfffc_0005_0004);
    add_write(REG_KERNEL_BOTTOM, 48'h0009_fff8_0007);
    add_pixel(16'sd10, 1'b0, '0);
    add_pixel(-16'sd20, 1'b0, '0);
    add_pixel(16'sd300, 1'b0, '0);
    add_pixel(-16'sd4000, 1'b0, '0);
    add_write(REG_FRAME_COLS, 48'd3);
    add_pixel(16'sd1, 1'b0, '0);
    add_pixel(-16'sd2, 1'b0, '0);
    add_pixel(16'sd3, 1'b0, '0);
    add_pixel(-16'sd4, 1'b0, '0);
    add_pixel(16'sd5, 1'b0, '0);
    add_pixel(-16'sd6, 1'b0, '0);
    add_pixel(16'sd7, 1'b0, '0);
    add_pixel(-16'sd8, 1'b0, '0);
    add_pixel(16'sh7fff, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[s]) begin
      if (steps[s].kind == STEP_WRITE) begin
        settle(SETTLE_CYCLES);
        write_reg(steps[s].idx, steps[s].value);
      end else begin
        send_pixel(steps[s].value[PIX_W-1:0]);
        if (steps[s].chk) pending_filtered[pending_filtered.size()-1].sum = steps[s].want;
      end
    end

    // sizes above the limit clamp to 128: one tall column, one wide row
    run_phase(8'd129, 8'd1, 1'b1, 128, 1'b1);
    run_phase(8'd1, 8'd200, 1'b1, 128, 1'b0);

    while (pixels_sent < PIXEL_TARGET) begin
      rows_w   = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      cols_w   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(7, 12))
                                              : 8'($urandom_range(0, 6));
      set_dims = ($urandom_range(0, 4) != 0);
      if (set_dims) area = clamp_dim(rows_w) * clamp_dim(cols_w);
      else area = clamp_dim(rows_reg) * clamp_dim(cols_reg);
      if ($urandom_range(0, 9) < 7 || area < 2) count = area * $urandom_range(1, 2);
      else count = $urandom_range(1, area - 1);
      if (count > PIXEL_TARGET - pixels_sent) count = PIXEL_TARGET - pixels_sent;
      run_phase(rows_w, cols_w, set_dims, count, ($urandom_range(0, 3) != 0));
    end

    settle(2 * SETTLE_CYCLES);
    if (pending_filtered.size() != 0) note_mismatch("results still pending at end of run");

    $display("Sent %0d pixels: directed table and %0d random phases; %0d results, %0d frames",
             pixels_sent, phases_run, results_seen, frames_done);
    $display("Frames ranged from 1x1 to 128 long, kernels from zero to full-scale; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS window_filter_3x3_clamped");
    end else begin
      $display("FAIL window_filter_3x3_clamped");
    end
    $finish;
  end

endmodule
